// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: hw/rtl/ntr_pkg.sv
// Types and constants for the node-to-element reduction block.
// No dependencies.
package ntr_pkg;
  localparam int NodeCnt = 8;
  localparam int ValW = 32;
  localparam int ResW = 35;

  typedef enum logic [2:0] {
    MODE_AVG = 3'd0,
    MODE_MIN = 3'd1,
    MODE_MAX = 3'd2,
    MODE_SUM = 3'd3,
    MODE_MED = 3'd4
  } mode_t;

  typedef struct packed {
    logic [3:0] node_count;
    logic signed [ValW-1:0] node_value_0;
    logic signed [ValW-1:0] node_value_1;
    logic signed [ValW-1:0] node_value_2;
    logic signed [ValW-1:0] node_value_3;
    logic signed [ValW-1:0] node_value_4;
    logic signed [ValW-1:0] node_value_5;
    logic signed [ValW-1:0] node_value_6;
    logic signed [ValW-1:0] node_value_7;
  } in_word_t;

  typedef struct packed {
    logic signed [ResW-1:0] reduced_value;
    logic empty_element;
  } out_word_t;
endpackage

// File: hw/rtl/node_to_element_reduce_top.sv
// Node-to-element reduction: average, min, max, sum or median of up to 8 values.
// 19 register stages, the last of them the output register.
// Throughput 1 word per cycle while out_stall is low.
// Stages: capture, adder tree, odd-even transposition sort (8 stages),
// select, 35-step restoring divider in 7 stages of 5 bits, output register.
// Stall freezes the pipe back to its first empty slot; an empty slot lets upstream advance.
// Synchronous active-high reset clears valid bits and the mode register.
// Depends on ntr_pkg.sv and assert_macros.svh.
`include "assert_macros.svh"
module node_to_element_reduce_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  ntr_pkg::in_word_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output ntr_pkg::out_word_t out_word
);
  import ntr_pkg::*;

  localparam int SortSt = NodeCnt;     // odd-even transposition stages
  localparam int DivW = ResW;          // quotient bits
  localparam int DivSt = DivW / 5;     // divider stages, 5 quotient bits per stage
  localparam int NSt = 2 + SortSt + 1 + DivSt + 1;

  typedef logic signed [ValW-1:0] val_t;
  typedef struct packed {
    val_t [NodeCnt-1:0] v;
    logic [3:0] n;        // saturated count
    logic [2:0] mode;
    logic signed [ResW-1:0] acc;   // running sum, then result
    logic [DivW-1:0] quo;          // magnitude being divided / quotient
    logic [DivW:0] rem;
    logic neg;
  } slot_t;

  logic [2:0] reduce_mode;
  always_ff @(posedge clk) begin
    if (rst) reduce_mode <= 3'(MODE_AVG);
    else if (cfg_we) reduce_mode <= cfg_data;
  end

  slot_t pipe [NSt-1];
  logic [NSt-1:0] vld;
  logic adv [NSt];

  // Each stage advances if it is empty or downstream is free.
  always_comb begin
    adv[NSt-1] = !vld[NSt-1] || !out_stall;
    for (int s = NSt-2; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
  end
  assign in_stall = !adv[0];

  // stage 0: capture with count saturation; unused slots are padded in stage 1
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv[0]) vld[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pipe[0].n <= (in_word.node_count > 4'(NodeCnt)) ? 4'(NodeCnt) : in_word.node_count;
      pipe[0].mode <= reduce_mode;
      pipe[0].v[0] <= in_word.node_value_0;
      pipe[0].v[1] <= in_word.node_value_1;
      pipe[0].v[2] <= in_word.node_value_2;
      pipe[0].v[3] <= in_word.node_value_3;
      pipe[0].v[4] <= in_word.node_value_4;
      pipe[0].v[5] <= in_word.node_value_5;
      pipe[0].v[6] <= in_word.node_value_6;
      pipe[0].v[7] <= in_word.node_value_7;
      pipe[0].acc <= '0;
      pipe[0].quo <= '0;
      pipe[0].rem <= '0;
      pipe[0].neg <= 1'b0;
    end
  end

  // stage 1: sum of used values through a balanced tree; unused lanes forced
  // high so the sort leaves them past the used ones
  slot_t s1;
  logic signed [ResW-1:0] term [NodeCnt];
  always_comb begin
    s1 = pipe[0];
    for (int i = 0; i < NodeCnt; i++) begin
      if (4'(i) < pipe[0].n) term[i] = ResW'(pipe[0].v[i]);
      else begin
        term[i] = '0;
        s1.v[i] = {1'b0, {(ValW-1){1'b1}}};
      end
    end
    s1.acc = ((term[0] + term[1]) + (term[2] + term[3])) +
             ((term[4] + term[5]) + (term[6] + term[7]));
  end
  always_ff @(posedge clk) begin
    if (rst) vld[1] <= 1'b0;
    else if (adv[1]) vld[1] <= vld[0];
  end
  always_ff @(posedge clk) if (adv[1]) pipe[1] <= s1;

  // padding with max keeps min/med right; max taken at index n-1 after sort
  genvar g;
  generate
    for (g = 0; g < SortSt; g++) begin : g_sort
      slot_t sn;
      always_comb begin
        sn = pipe[1+g];
        for (int k = (g % 2); k + 1 < NodeCnt; k += 2) begin
          if (pipe[1+g].v[k] > pipe[1+g].v[k+1]) begin
            sn.v[k] = pipe[1+g].v[k+1];
            sn.v[k+1] = pipe[1+g].v[k];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rst) vld[2+g] <= 1'b0;
        else if (adv[2+g]) vld[2+g] <= vld[1+g];
      end
      always_ff @(posedge clk) if (adv[2+g]) pipe[2+g] <= sn;
    end
  endgenerate

  // select stage: pick result, set up divide of |sum| by n
  localparam int SelI = 2 + SortSt;
  slot_t ss;
  logic signed [ResW-1:0] sum_c;
  always_comb begin
    ss = pipe[SelI-1];
    sum_c = pipe[SelI-1].acc;
    ss.neg = 1'b0;
    ss.quo = '0;
    ss.rem = '0;
    case (pipe[SelI-1].mode)
      MODE_MIN: ss.acc = ResW'(pipe[SelI-1].v[0]);
      MODE_MAX: ss.acc = ResW'(pipe[SelI-1].v[3'(pipe[SelI-1].n - 4'd1)]);
      MODE_SUM: ss.acc = sum_c;
      MODE_MED: ss.acc = ResW'(pipe[SelI-1].v[3'(pipe[SelI-1].n >> 1)]);
      MODE_AVG: begin
        ss.acc = '0;
        ss.neg = sum_c[ResW-1];
        ss.quo = sum_c[ResW-1] ? DivW'(-sum_c) : DivW'(sum_c);
      end
      default: ss.acc = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) vld[SelI] <= 1'b0;
    else if (adv[SelI]) vld[SelI] <= vld[SelI-1];
  end
  always_ff @(posedge clk) if (adv[SelI]) pipe[SelI] <= ss;

  // restoring divider, 5 quotient bits per stage, MSB first
  generate
    for (g = 0; g < DivSt; g++) begin : g_div
      slot_t dn;
      logic [DivW:0] r;
      always_comb begin
        dn = pipe[SelI+g];
        r = pipe[SelI+g].rem;
        for (int b = 0; b < 5; b++) begin
          r = {r[DivW-1:0], dn.quo[DivW-1]};
          dn.quo = {dn.quo[DivW-2:0], 1'b0};
          if (r >= (DivW+1)'(pipe[SelI+g].n)) begin
            r = r - (DivW+1)'(pipe[SelI+g].n);
            dn.quo[0] = 1'b1;
          end
        end
        dn.rem = r;
      end
      always_ff @(posedge clk) begin
        if (rst) vld[SelI+1+g] <= 1'b0;
        else if (adv[SelI+1+g]) vld[SelI+1+g] <= vld[SelI+g];
      end
      always_ff @(posedge clk) if (adv[SelI+1+g]) pipe[SelI+1+g] <= dn;
    end
  endgenerate

  // output stage
  localparam int LastI = SelI + DivSt;
  slot_t lst;
  out_word_t ow;
  assign lst = pipe[LastI];
  always_comb begin
    ow.empty_element = (lst.n == 4'd0);
    if (lst.n == 4'd0) ow.reduced_value = '0;
    else if (lst.mode == 3'(MODE_AVG))
      ow.reduced_value = lst.neg ? -ResW'(lst.quo) : ResW'(lst.quo);
    else ow.reduced_value = lst.acc;
  end
  always_ff @(posedge clk) begin
    if (rst) vld[NSt-1] <= 1'b0;
    else if (adv[NSt-1]) vld[NSt-1] <= vld[LastI];
  end
  always_ff @(posedge clk) if (adv[NSt-1]) out_word <= ow;
  assign out_valid = vld[NSt-1];

  `ASSERT_CLK(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_word), "output word changed under stall")
  `ASSERT_CLK(a_empty, clk, rst, out_valid && out_word.empty_element |-> out_word.reduced_value == '0, "empty element with nonzero value")
  `ASSERT_CLK(a_stall, clk, rst, in_stall |-> vld[0] && out_stall, "input stalled without full pipe")
endmodule

// File: dv/tb_node_to_element_reduce_top.sv
// Self-checking bench for node_to_element_reduce_top: directed table plus random elements.
// Each accepted word is reduced by a local predictor and compared with the output word.
// Depends on ntr_pkg.sv and the RTL top.
`timescale 1ns / 100ps
module tb_node_to_element_reduce_top;
  import ntr_pkg::*;

  localparam int Latency = 19;
  localparam longint CycleLimit = 400000;
  localparam int NumRandom = 900;
  localparam logic [2:0] ModeBadA = 3'd5;
  localparam logic [2:0] ModeBadB = 3'd7;
  localparam logic [ValW-1:0] ValMin = 32'h8000_0000;
  localparam logic [ValW-1:0] ValMax = 32'h7fff_ffff;

  typedef struct {
    logic [3:0] cnt;
    logic [ValW-1:0] v;
    logic [ResW-1:0] res;
    logic emp;
    bit typed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  logic [2:0] cur_mode;
  out_word_t expected_words[$];
  int mismatches = 0;
  longint cycle_cnt = 0;
  bit stall_pattern_on = 1'b1;

  node_to_element_reduce_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic out_word_t reduce_element(in_word_t w, logic [2:0] mode);
    longint vals[8];
    longint acc;
    longint key;
    int n;
    int j;
    out_word_t r;
    n = (w.node_count > NodeCnt) ? NodeCnt : int'(w.node_count);
    r = '0;
    if (n == 0) begin
      r.empty_element = 1'b1;
      return r;
    end
    vals[0] = longint'(w.node_value_0); vals[1] = longint'(w.node_value_1);
    vals[2] = longint'(w.node_value_2); vals[3] = longint'(w.node_value_3);
    vals[4] = longint'(w.node_value_4); vals[5] = longint'(w.node_value_5);
    vals[6] = longint'(w.node_value_6); vals[7] = longint'(w.node_value_7);
    acc = 0;
    case (mode)
      MODE_AVG, MODE_SUM: begin
        for (int i = 0; i < n; i++) acc += vals[i];
        if (mode == MODE_AVG) acc = acc / n; // SV division truncates toward zero
      end
      MODE_MIN: begin
        acc = vals[0];
        for (int i = 1; i < n; i++) if (vals[i] < acc) acc = vals[i];
      end
      MODE_MAX: begin
        acc = vals[0];
        for (int i = 1; i < n; i++) if (vals[i] > acc) acc = vals[i];
      end
      MODE_MED: begin
        for (int i = 1; i < n; i++) begin
          key = vals[i];
          j = i;
          while (j > 0 && vals[j-1] > key) begin
            vals[j] = vals[j-1];
            j--;
          end
          vals[j] = key;
        end
        acc = vals[n/2];
      end
      default: acc = 0;
    endcase
    r.reduced_value = acc[ResW-1:0];
    return r;
  endfunction

  // one word offered and held until accepted
  task automatic send_element(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(reduce_element(w, cur_mode));
  endtask

  task automatic send_burst_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_set_mode(logic [2:0] mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = mode;
  endtask

  function automatic logic [ValW-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return ValMin;
      1: return ValMax;
      2: return ValW'($urandom_range(0, 20)) - ValW'(10);
      default: return ValW'($urandom());
    endcase
  endfunction

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word);
      end else begin
        if (out_word.reduced_value !== expected_words[0].reduced_value ||
            out_word.empty_element !== expected_words[0].empty_element) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d empty %b, got value %0d empty %b",
                     expected_words[0].reduced_value, expected_words[0].empty_element,
                     out_word.reduced_value, out_word.empty_element);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // receiver stall pattern: toggles between quiet and busy stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_pattern_on <= ~stall_pattern_on;
    out_stall <= stall_pattern_on ? ($urandom_range(0, 3) == 0) : 1'b0;
  end

  initial begin
    row_t table_rows[$];
    in_word_t w;
    logic [2:0] modes[8];
    out_word_t pred;
    int wait_cnt;
    modes = '{MODE_AVG, MODE_MIN, MODE_MAX, MODE_SUM, MODE_MED, ModeBadA, ModeBadB,
              MODE_AVG};
    cur_mode = MODE_AVG;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, mode average after reset; all nodes share one value
    table_rows = '{
      '{4'd0, ValMax, 35'd0, 1'b1, 1'b1},
      '{4'd1, ValMax, 35'd2147483647, 1'b0, 1'b1},
      '{4'd8, ValMin, -35'sd2147483648, 1'b0, 1'b1},
      '{4'd15, ValMax, 35'd2147483647, 1'b0, 1'b1},
      '{4'd3, 32'hffff_fffd, 35'd0, 1'b0, 1'b0},
      '{4'd8, 32'hffff_ffff, 35'd0, 1'b0, 1'b0}
    };
    foreach (table_rows[k]) begin
      w = {table_rows[k].cnt, {8{table_rows[k].v}}};
      pred = reduce_element(w, cur_mode);
      if (table_rows[k].typed && pred !== {table_rows[k].res, table_rows[k].emp}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: exp value %0d empty %b, predictor value %0d empty %b",
                   k, table_rows[k].res, table_rows[k].emp,
                   pred.reduced_value, pred.empty_element);
      end
      send_element(w);
    end
    // extremes mixed in every mode, including unused codes 5 and 7
    foreach (modes[m]) begin
      drain_and_set_mode(modes[m]);
      for (int c = 0; c <= 9; c += 3) begin
        w = {4'(c == 9 ? 8 : c), ValMax, ValMin, ValMax, ValMin, 32'd5,
             32'hffff_fffb, ValMax, ValMax};
        send_element(w);
      end
      send_element({4'd8, ValMax, ValMax, ValMax, ValMax, ValMax, ValMax, ValMax, ValMax});
      send_element({4'd8, ValMin, ValMin, ValMin, ValMin, ValMin, ValMin, ValMin, ValMin});
    end

    // random part, phases through modes
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 120 == 0) drain_and_set_mode(3'($urandom_range(0, 7)));
      w.node_count = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8));
      w.node_value_0 = random_value(); w.node_value_1 = random_value();
      w.node_value_2 = random_value(); w.node_value_3 = random_value();
      w.node_value_4 = random_value(); w.node_value_5 = random_value();
      w.node_value_6 = random_value(); w.node_value_7 = random_value();
      send_element(w);
      send_burst_gap();
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (expected_words.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
